@@ sv/mevrb_pkg.sv @@
// shared types and constants of the midi event retime and bank remap block
package mevrb_pkg;

  localparam int unsigned CHANNELS_DEF = 16;

  localparam int unsigned TICK_W     = 32;
  localparam int unsigned RES_W      = 16;
  localparam int unsigned PROD_W     = TICK_W + RES_W;
  localparam int unsigned CH_W       = 4;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned DATA_W     = 7;
  localparam int unsigned BANK_W     = 14;
  localparam int unsigned SHIFT_W    = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned DIV_CNT_W  = $clog2(PROD_W);

  localparam logic [BANK_W-1:0] BANK_MAX_MMA = 14'h3FFF;
  localparam logic [BANK_W-1:0] BANK_MAX_STD = 14'd127;
  localparam logic [BANK_W-1:0] BANK_HI_MASK = 14'h3F80;
  localparam logic [BANK_W-1:0] BANK_LO_MASK = 14'h007F;

  typedef enum logic [CFG_IDX_W-1:0] {
    CfgSrcRes,
    CfgTgtRes,
    CfgStartOffset,
    CfgBankShift,
    CfgMmaMode
  } cfg_reg_e;

  typedef enum logic [KIND_W-1:0] {
    KindMeta,
    KindOther,
    KindCoarse,
    KindFine
  } kind_e;

  typedef enum logic {
    OpEvent,
    OpEnd
  } op_e;

  // request into the divider
  typedef struct packed {
    logic               start;
    logic [PROD_W-1:0]  dividend;
    logic [RES_W-1:0]   divisor;
  } div_req_t;

  // response from the divider
  typedef struct packed {
    logic               done;
    logic [TICK_W-1:0]  quot;
  } div_rsp_t;

endpackage

@@ sv/mevrb_div.sv @@
// radix-2 restoring divider, one quotient bit per cycle
module mevrb_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mevrb_pkg::div_req_t req_i,
  output mevrb_pkg::div_rsp_t rsp_o
);

  logic                                busy_q;
  logic                                done_q;
  logic [mevrb_pkg::DIV_CNT_W-1:0]     cnt_q;
  logic [mevrb_pkg::PROD_W-1:0]        acc_q;
  logic [mevrb_pkg::RES_W-1:0]         rem_q;
  logic [mevrb_pkg::RES_W-1:0]         dvs_q;

  logic [mevrb_pkg::RES_W:0]           shifted;
  logic [mevrb_pkg::RES_W:0]           diff;
  logic                                ge;

  always_comb begin
    shifted = {rem_q, acc_q[mevrb_pkg::PROD_W-1]};
    ge      = shifted >= {1'b0, dvs_q};
    diff    = shifted - {1'b0, dvs_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= mevrb_pkg::DIV_CNT_W'(mevrb_pkg::PROD_W - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q <= req_i.dividend;
      rem_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      // quotient bits shift in where dividend bits leave
      acc_q <= {acc_q[mevrb_pkg::PROD_W-2:0], ge};
      rem_q <= ge ? diff[mevrb_pkg::RES_W-1:0] : shifted[mevrb_pkg::RES_W-1:0];
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = acc_q[mevrb_pkg::TICK_W-1:0];

endmodule

@@ sv/midi_event_retime_bank_remap_top.sv @@
// top level of the midi event retime and bank remap block
// Takes one track event or end-of-track request at a time and is not ready while it works
// on it. A track event whose tick is rescaled passes through the 32x16 multiply, the
// radix-2 divider (one quotient bit per cycle over the 48-bit product), a handoff, the
// load of the output register and the return to idle; when the tick is kept as is the
// event goes straight to the output register load. An end-of-track request gives a
// single status result, or scans the channels and injects a coarse/fine pair for each
// used channel. Results wait in an output register, and a stalled output holds the
// sequencer. Configuration writes are always taken.
module midi_event_retime_bank_remap_top #(
  parameter int unsigned CHANNELS = mevrb_pkg::CHANNELS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,

  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [mevrb_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [mevrb_pkg::CFG_DATA_W-1:0]  cfg_data_i,

  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              operation_i,
  input  logic [mevrb_pkg::TICK_W-1:0]      event_tick_i,
  input  logic [mevrb_pkg::CH_W-1:0]        event_channel_i,
  input  logic [mevrb_pkg::KIND_W-1:0]      event_kind_i,
  input  logic [mevrb_pkg::DATA_W-1:0]      data_value_i,

  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [mevrb_pkg::TICK_W-1:0]      out_tick_o,
  output logic [mevrb_pkg::CH_W-1:0]        out_channel_o,
  output logic [mevrb_pkg::KIND_W-1:0]      out_kind_o,
  output logic [mevrb_pkg::DATA_W-1:0]      out_data_o,
  output logic                              injected_o,
  output logic                              error_o,
  output logic                              last_o
);

  localparam int unsigned IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef enum logic [2:0] {
    StIdle,
    StMul,
    StDiv,
    StEmitEv,
    StEot,
    StScan,
    StEmitHi,
    StEmitLo
  } state_e;

  // configuration registers
  logic [mevrb_pkg::RES_W-1:0]    src_res_q;
  logic [mevrb_pkg::RES_W-1:0]    tgt_res_q;
  logic [mevrb_pkg::TICK_W-1:0]   start_offset_q;
  logic [mevrb_pkg::SHIFT_W-1:0]  bank_shift_q;
  logic                           mma_mode_q;

  state_e                         state_q;
  logic [mevrb_pkg::TICK_W-1:0]   tick_q;
  logic [mevrb_pkg::TICK_W-1:0]   ret_q;
  logic [mevrb_pkg::CH_W-1:0]     ev_ch_q;
  mevrb_pkg::kind_e               ev_kind_q;
  logic [mevrb_pkg::DATA_W-1:0]   ev_dv_q;
  logic [mevrb_pkg::CH_W-1:0]     ch_cnt_q;

  logic [mevrb_pkg::BANK_W-1:0]   bank_q [CHANNELS];
  logic [CHANNELS-1:0]            used_q;
  logic                           ovf_seen_q;

  logic                           out_valid_q;
  logic [mevrb_pkg::TICK_W-1:0]   out_tick_q;
  logic [mevrb_pkg::CH_W-1:0]     out_channel_q;
  logic [mevrb_pkg::KIND_W-1:0]   out_kind_q;
  logic [mevrb_pkg::DATA_W-1:0]   out_data_q;
  logic                           injected_q;
  logic                           error_q;
  logic                           last_q;

  mevrb_pkg::div_req_t            div_req;
  mevrb_pkg::div_rsp_t            div_rsp;

  logic                           out_free;
  logic                           out_load;
  logic                           bypass;
  logic [mevrb_pkg::PROD_W-1:0]   prod;
  logic [IdxW-1:0]                ev_idx;
  logic [IdxW-1:0]                cnt_idx;
  logic                           tracked;
  logic                           is_coarse;
  logic                           is_bank;
  logic [mevrb_pkg::BANK_W-1:0]   old_bank;
  logic [mevrb_pkg::BANK_W-1:0]   new_bank;
  logic [mevrb_pkg::BANK_W:0]     remap_sum;
  logic                           remap_ovf;
  logic [mevrb_pkg::DATA_W-1:0]   remap_data;
  logic                           ev_ovf;
  logic [mevrb_pkg::DATA_W-1:0]   ev_data;
  logic                           eot_ovf;
  logic [mevrb_pkg::DATA_W-1:0]   eot_hi;
  logic [mevrb_pkg::DATA_W-1:0]   eot_lo;
  logic                           more_above;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_res_q      <= 16'd48;
      tgt_res_q      <= 16'd48;
      start_offset_q <= '0;
      bank_shift_q   <= '0;
      mma_mode_q     <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (mevrb_pkg::cfg_reg_e'(cfg_index_i))
        mevrb_pkg::CfgSrcRes:      src_res_q      <= cfg_data_i[mevrb_pkg::RES_W-1:0];
        mevrb_pkg::CfgTgtRes:      tgt_res_q      <= cfg_data_i[mevrb_pkg::RES_W-1:0];
        mevrb_pkg::CfgStartOffset: start_offset_q <= cfg_data_i[mevrb_pkg::TICK_W-1:0];
        mevrb_pkg::CfgBankShift:   bank_shift_q   <= cfg_data_i[mevrb_pkg::SHIFT_W-1:0];
        mevrb_pkg::CfgMmaMode:     mma_mode_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // retiming datapath
  assign bypass = (src_res_q == '0) || (tgt_res_q == '0) || (src_res_q == tgt_res_q);
  assign prod   = mevrb_pkg::PROD_W'(tick_q) * mevrb_pkg::PROD_W'(tgt_res_q);

  assign div_req.start    = (state_q == StMul);
  assign div_req.dividend = prod + mevrb_pkg::PROD_W'(src_res_q >> 1);
  assign div_req.divisor  = src_res_q;

  mevrb_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign out_free = !out_valid_q || out_ready_i;
  assign ev_idx   = ev_ch_q[IdxW-1:0];
  assign cnt_idx  = ch_cnt_q[IdxW-1:0];

  // output register takes a new result this cycle
  assign out_load = out_free && ((state_q == StEmitEv) || (state_q == StEmitHi) ||
                                 (state_q == StEmitLo) ||
                                 ((state_q == StEot) && (eot_ovf || (used_q == '0))));

  // bank update and remap of the held event
  always_comb begin
    tracked   = ({1'b0, ev_ch_q} < (mevrb_pkg::CH_W + 1)'(CHANNELS));
    is_coarse = (ev_kind_q == mevrb_pkg::KindCoarse);
    is_bank   = is_coarse || (ev_kind_q == mevrb_pkg::KindFine);
    old_bank  = tracked ? bank_q[ev_idx] : '0;
    if (mma_mode_q) begin
      new_bank = is_coarse ? {ev_dv_q, old_bank[6:0]}
                           : ((old_bank & mevrb_pkg::BANK_HI_MASK) | {7'b0, ev_dv_q});
    end else begin
      new_bank = is_coarse ? {7'b0, ev_dv_q} : old_bank;
    end
    remap_sum = {1'b0, new_bank} + (mevrb_pkg::BANK_W + 1)'(bank_shift_q);
    if (mma_mode_q) begin
      remap_ovf  = remap_sum > {1'b0, mevrb_pkg::BANK_MAX_MMA};
      remap_data = is_coarse ? remap_sum[13:7] : remap_sum[6:0];
    end else begin
      remap_ovf  = remap_sum > {1'b0, mevrb_pkg::BANK_MAX_STD};
      remap_data = is_coarse ? remap_sum[6:0] : '0;
    end
    ev_ovf = is_bank && remap_ovf;
    if (!is_bank) begin
      ev_data = '0;
    end else if (remap_ovf) begin
      ev_data = ev_dv_q;
    end else begin
      ev_data = remap_data;
    end
  end

  // injected bytes come from bank zero
  always_comb begin
    eot_ovf = !mma_mode_q && (bank_shift_q > 8'd127);
    if (mma_mode_q) begin
      eot_hi = {6'b0, bank_shift_q[7]};
      eot_lo = bank_shift_q[6:0] & mevrb_pkg::BANK_LO_MASK[6:0];
    end else begin
      eot_hi = bank_shift_q[6:0];
      eot_lo = '0;
    end
  end

  always_comb begin
    more_above = 1'b0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (used_q[i] && (mevrb_pkg::CH_W'(i) > ch_cnt_q)) begin
        more_above = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      tick_q        <= '0;
      ret_q         <= '0;
      ev_ch_q       <= '0;
      ev_kind_q     <= mevrb_pkg::KindMeta;
      ev_dv_q       <= '0;
      ch_cnt_q      <= '0;
      used_q        <= '0;
      ovf_seen_q    <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        bank_q[i] <= '0;
      end
      out_valid_q   <= 1'b0;
      out_tick_q    <= '0;
      out_channel_q <= '0;
      out_kind_q    <= '0;
      out_data_q    <= '0;
      injected_q    <= 1'b0;
      error_q       <= 1'b0;
      last_q        <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && !out_load) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            tick_q    <= event_tick_i;
            ret_q     <= event_tick_i;
            ev_ch_q   <= event_channel_i;
            ev_kind_q <= mevrb_pkg::kind_e'(event_kind_i);
            ev_dv_q   <= data_value_i;
            priority if (mevrb_pkg::op_e'(operation_i) == mevrb_pkg::OpEnd) begin
              state_q <= StEot;
            end else if (bypass) begin
              state_q <= StEmitEv;
            end else begin
              state_q <= StMul;
            end
          end
        end
        StMul: begin
          state_q <= StDiv;
        end
        StDiv: begin
          if (div_rsp.done) begin
            ret_q   <= div_rsp.quot;
            state_q <= StEmitEv;
          end
        end
        StEmitEv: begin
          if (out_free) begin
            out_valid_q   <= 1'b1;
            out_tick_q    <= ret_q + start_offset_q;
            out_channel_q <= ev_ch_q;
            out_kind_q    <= ev_kind_q;
            out_data_q    <= ev_data;
            injected_q    <= 1'b0;
            error_q       <= ovf_seen_q || ev_ovf;
            last_q        <= 1'b1;
            if (ev_ovf) begin
              ovf_seen_q <= 1'b1;
            end
            if (tracked) begin
              if (ev_kind_q != mevrb_pkg::KindMeta) begin
                used_q[ev_idx] <= 1'b1;
              end
              if (is_bank) begin
                bank_q[ev_idx] <= new_bank;
              end
            end
            state_q <= StIdle;
          end
        end
        StEot: begin
          priority if (eot_ovf || (used_q == '0)) begin
            // single status result, then clear
            if (out_free) begin
              out_valid_q   <= 1'b1;
              out_tick_q    <= start_offset_q;
              out_channel_q <= '0;
              out_kind_q    <= mevrb_pkg::KindMeta;
              out_data_q    <= '0;
              injected_q    <= 1'b0;
              error_q       <= ovf_seen_q || eot_ovf;
              last_q        <= 1'b1;
              used_q        <= '0;
              ovf_seen_q    <= 1'b0;
              for (int i = 0; i < CHANNELS; i++) begin
                bank_q[i] <= '0;
              end
              state_q <= StIdle;
            end
          end else begin
            ch_cnt_q <= '0;
            state_q  <= StScan;
          end
        end
        StScan: begin
          if (used_q[cnt_idx]) begin
            state_q <= StEmitHi;
          end else begin
            ch_cnt_q <= ch_cnt_q + 1'b1;
          end
        end
        StEmitHi: begin
          if (out_free) begin
            out_valid_q   <= 1'b1;
            out_tick_q    <= start_offset_q;
            out_channel_q <= ch_cnt_q;
            out_kind_q    <= mevrb_pkg::KindCoarse;
            out_data_q    <= eot_hi;
            injected_q    <= 1'b1;
            error_q       <= ovf_seen_q;
            last_q        <= 1'b0;
            state_q       <= StEmitLo;
          end
        end
        StEmitLo: begin
          if (out_free) begin
            out_valid_q   <= 1'b1;
            out_tick_q    <= start_offset_q;
            out_channel_q <= ch_cnt_q;
            out_kind_q    <= mevrb_pkg::KindFine;
            out_data_q    <= eot_lo;
            injected_q    <= 1'b1;
            error_q       <= ovf_seen_q;
            last_q        <= !more_above;
            if (more_above) begin
              ch_cnt_q <= ch_cnt_q + 1'b1;
              state_q  <= StScan;
            end else begin
              used_q     <= '0;
              ovf_seen_q <= 1'b0;
              for (int i = 0; i < CHANNELS; i++) begin
                bank_q[i] <= '0;
              end
              state_q <= StIdle;
            end
          end
        end
      endcase
    end
  end

  assign in_ready_o    = (state_q == StIdle);
  assign out_valid_o   = out_valid_q;
  assign out_tick_o    = out_tick_q;
  assign out_channel_o = out_channel_q;
  assign out_kind_o    = out_kind_q;
  assign out_data_o    = out_data_q;
  assign injected_o    = injected_q;
  assign error_o       = error_q;
  assign last_o        = last_q;

  // divider only finishes while the sequencer waits for it
  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == StDiv))
    else $error("divider finished outside of the divide wait");

  // channel scan never runs past the tracked channels
  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan) |-> ({1'b0, ch_cnt_q} < (mevrb_pkg::CH_W + 1)'(CHANNELS)))
    else $error("channel scan beyond tracked channels");

  // the final injected pair clears the per-track state
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmitLo && out_free && !more_above) |=>
      (used_q == '0 && !ovf_seen_q))
    else $error("track state not cleared after end of track");

endmodule

@@ verif/tb.sv @@
// testbench for the midi event retime and bank remap block
`timescale 1ns / 100ps

module tb;
  import mevrb_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned TAIL_CYCLES = 100;

  typedef struct {
    logic [TICK_W-1:0] tick;
    logic [CH_W-1:0]   ch;
    kind_e             kind;
    logic [DATA_W-1:0] data;
    logic              inj;
    logic              err;
    logic              last;
  } bank_event_t;

  class bank_remap_scoreboard;
    logic [RES_W-1:0]   src_res;
    logic [RES_W-1:0]   tgt_res;
    logic [TICK_W-1:0]  start_off;
    logic [SHIFT_W-1:0] shift;
    logic               mma;
    logic [BANK_W-1:0]  bank_q [CHANNELS_DEF];
    logic               used_q [CHANNELS_DEF];
    logic               overflow;
    bank_event_t        expected_q [$];
    int                 fails;

    function new();
      src_res   = 16'd48;
      tgt_res   = 16'd48;
      start_off = '0;
      shift     = '0;
      mma       = 1'b0;
      fails     = 0;
      clear_tracks();
    endfunction

    function void clear_tracks();
      foreach (bank_q[c]) begin
        bank_q[c] = '0;
        used_q[c] = 1'b0;
      end
      overflow = 1'b0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CfgSrcRes:      src_res   = val[RES_W-1:0];
        CfgTgtRes:      tgt_res   = val[RES_W-1:0];
        CfgStartOffset: start_off = val;
        CfgBankShift:   shift     = val[SHIFT_W-1:0];
        CfgMmaMode:     mma       = val[0];
        default: ;
      endcase
    endfunction

    function logic [TICK_W-1:0] retime(logic [TICK_W-1:0] tick);
      logic [63:0] t;
      t = {32'b0, tick};
      if (src_res != 0 && tgt_res != 0 && src_res != tgt_res) begin
        t = (t * {48'b0, tgt_res} + {49'b0, src_res[RES_W-1:1]}) / {48'b0, src_res};
      end
      return t[TICK_W-1:0] + start_off;
    endfunction

    // returns 0 when bank plus shift leaves the bank range
    function bit remap(logic [BANK_W-1:0] bank, kind_e kind, output logic [DATA_W-1:0] data);
      logic [BANK_W:0] r;
      r = {1'b0, bank} + {7'b0, shift};
      data = '0;
      if (mma) begin
        if (r > {1'b0, BANK_MAX_MMA}) return 1'b0;
        data = (kind == KindCoarse) ? r[13:7] : r[6:0];
      end else begin
        if (r > {1'b0, BANK_MAX_STD}) return 1'b0;
        data = (kind == KindCoarse) ? r[6:0] : '0;
      end
      return 1'b1;
    endfunction

    function void add_expected(logic [TICK_W-1:0] tick, logic [CH_W-1:0] ch, kind_e kind,
                               logic [DATA_W-1:0] data, logic inj, logic last);
      bank_event_t e;
      e.tick = tick;
      e.ch   = ch;
      e.kind = kind;
      e.data = data;
      e.inj  = inj;
      e.err  = overflow;
      e.last = last;
      expected_q.insert(expected_q.size(), e);
    endfunction

    function void note_request(op_e op, logic [TICK_W-1:0] tick, logic [CH_W-1:0] ch,
                               kind_e kind, logic [DATA_W-1:0] dv);
      logic [TICK_W-1:0] t;
      logic [BANK_W-1:0] bank;
      logic [DATA_W-1:0] data;
      logic [DATA_W-1:0] hi;
      logic [DATA_W-1:0] lo;
      bit                ok;
      int                last_ch;
      int                c;
      if (op == OpEvent) begin
        t = retime(tick);
        data = '0;
        if (kind != KindMeta) used_q[ch] = 1'b1;
        if (kind == KindCoarse || kind == KindFine) begin
          bank = bank_q[ch];
          if (mma) begin
            bank = (kind == KindCoarse) ? ({dv, 7'b0} | (bank & BANK_LO_MASK))
                                        : ((bank & BANK_HI_MASK) | {7'b0, dv});
          end else if (kind == KindCoarse) begin
            bank = {7'b0, dv};
          end
          bank_q[ch] = bank;
          if (!remap(bank, kind, data)) begin
            overflow = 1'b1;
            data = dv;
          end
        end
        add_expected(t, ch, kind, data, 1'b0, 1'b1);
      end else begin
        hi = '0;
        lo = '0;
        ok = remap('0, KindCoarse, hi) && remap('0, KindFine, lo);
        if (!ok) overflow = 1'b1;
        last_ch = -1;
        if (ok) begin
          for (c = 0; c < CHANNELS_DEF; c++) begin
            if (used_q[c]) last_ch = c;
          end
        end
        // no used channel or a bad shift gives one status result
        if (last_ch < 0) begin
          add_expected(start_off, '0, KindMeta, '0, 1'b0, 1'b1);
        end else begin
          for (c = 0; c <= last_ch; c++) begin
            if (used_q[c]) begin
              add_expected(start_off, c[CH_W-1:0], KindCoarse, hi, 1'b1, 1'b0);
              add_expected(start_off, c[CH_W-1:0], KindFine, lo, 1'b1, c == last_ch);
            end
          end
        end
        clear_tracks();
      end
    endfunction

    function void cmp_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s: expected %0h, got %0h", name, exp_v, act_v);
        fails++;
      end
    endfunction

    function void check_result(bank_event_t got);
      bank_event_t e;
      if (expected_q.size() == 0) begin
        $error("result with no request pending: tick %0h channel %0d", got.tick, got.ch);
        fails++;
        return;
      end
      e = expected_q.pop_front();
      cmp_field("out_tick", e.tick, got.tick);
      cmp_field("out_channel", e.ch, got.ch);
      cmp_field("out_kind", e.kind, got.kind);
      cmp_field("out_data", e.data, got.data);
      cmp_field("injected", e.inj, got.inj);
      cmp_field("error", e.err, got.err);
      cmp_field("last", e.last, got.last);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic                  operation_i;
  logic [TICK_W-1:0]     event_tick_i;
  logic [CH_W-1:0]       event_channel_i;
  logic [KIND_W-1:0]     event_kind_i;
  logic [DATA_W-1:0]     data_value_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [TICK_W-1:0]     out_tick_o;
  logic [CH_W-1:0]       out_channel_o;
  logic [KIND_W-1:0]     out_kind_o;
  logic [DATA_W-1:0]     out_data_o;
  logic                  injected_o;
  logic                  error_o;
  logic                  last_o;

  bank_remap_scoreboard sb;
  bank_event_t          seen;
  bit                   in_steady;
  bit                   out_steady;
  bit                   hold_req;
  int                   stall_left;
  int unsigned          cycle_count;

  midi_event_retime_bank_remap_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .event_tick_i   (event_tick_i),
    .event_channel_i(event_channel_i),
    .event_kind_i   (event_kind_i),
    .data_value_i   (data_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_tick_o     (out_tick_o),
    .out_channel_o  (out_channel_o),
    .out_kind_o     (out_kind_o),
    .out_data_o     (out_data_o),
    .injected_o     (injected_o),
    .error_o        (error_o),
    .last_o         (last_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [TICK_W-1:0] rand_tick();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return $urandom_range(0, 5000);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] rand_dv();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 7'd127;
      default: return 7'($urandom_range(0, 127));
    endcase
  endfunction

  // bank selects dominate so that the bank state gets exercised
  function automatic kind_e rand_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return KindMeta;
    if (r < 35) return KindOther;
    if (r < 70) return KindCoarse;
    return KindFine;
  endfunction

  function automatic logic [RES_W-1:0] pick_res();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return 16'd1;
      3:       return 16'd48;
      4:       return 16'd96;
      5:       return 16'd480;
      default: return 16'($urandom_range(1, 65535));
    endcase
  endfunction

  function automatic logic [SHIFT_W-1:0] pick_shift();
    case ($urandom_range(0, 7))
      0:       return 8'd255;
      1:       return 8'd128;
      default: return 8'($urandom_range(0, 8));
    endcase
  endfunction

  // output side: random stalls plus one long hold when asked
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req = 1'b0;
      stall_left = HOLD_CYCLES;
    end
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else begin
      out_ready_i <= 1'b1;
      if (!out_steady && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen.tick = out_tick_o;
      seen.ch   = out_channel_o;
      seen.kind = kind_e'(out_kind_o);
      seen.data = out_data_o;
      seen.inj  = injected_o;
      seen.err  = error_o;
      seen.last = last_o;
      sb.check_result(seen);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("midi_event_retime_bank_remap_top test failed");
    $finish;
  end

  task automatic send_item(op_e op, logic [TICK_W-1:0] tick, logic [CH_W-1:0] ch,
                           kind_e kind, logic [DATA_W-1:0] dv);
    int gap;
    gap = in_steady ? 0 : pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    operation_i     <= op;
    event_tick_i    <= tick;
    event_channel_i <= ch;
    event_kind_i    <= kind;
    data_value_i    <= dv;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(op, tick, ch, kind, dv);
  endtask

  task automatic send_event(logic [TICK_W-1:0] tick, logic [CH_W-1:0] ch, kind_e kind,
                            logic [DATA_W-1:0] dv);
    send_item(OpEvent, tick, ch, kind, dv);
  endtask

  // the other fields of an end of track request are don't care
  task automatic send_end();
    send_item(OpEnd, $urandom(), 4'($urandom_range(0, 15)), kind_e'(2'($urandom_range(0, 3))),
              7'($urandom_range(0, 127)));
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_cfg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_config(logic [RES_W-1:0] src, logic [RES_W-1:0] tgt,
                            logic [TICK_W-1:0] off, logic [SHIFT_W-1:0] shift, logic mma);
    drain();
    write_cfg(CfgSrcRes, {16'b0, src});
    write_cfg(CfgTgtRes, {16'b0, tgt});
    write_cfg(CfgStartOffset, off);
    write_cfg(CfgBankShift, {24'b0, shift});
    write_cfg(CfgMmaMode, {31'b0, mma});
  endtask

  initial begin
    int p;
    int c;
    int n;
    sb              = new();
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = '0;
    cfg_data_i      = '0;
    in_valid_i      = 1'b0;
    operation_i     = 1'b0;
    event_tick_i    = '0;
    event_channel_i = '0;
    event_kind_i    = '0;
    data_value_i    = '0;
    out_ready_i     = 1'b0;
    in_steady       = 1'b0;
    out_steady      = 1'b0;
    hold_req        = 1'b0;
    stall_left      = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: equal resolutions keep the tick
    send_event('0, 4'd0, KindMeta, '0);
    send_event('1, 4'd15, KindOther, 7'd127);
    send_event(32'd100, 4'd3, KindCoarse, 7'd127);
    send_event(32'd101, 4'd3, KindFine, '0);
    send_event(32'd102, 4'd15, KindCoarse, '0);
    send_end();
    send_end();

    // rounding, offset wrap, and a sticky overflow
    set_config(16'd96, 16'd48, '1, 8'd1, 1'b0);
    send_event(32'd95, 4'd1, KindOther, '0);
    send_event(32'd200, 4'd2, KindCoarse, 7'd127);
    send_event('1, 4'd2, KindFine, 7'd5);
    send_end();
    send_event(32'd7, 4'd0, KindMeta, 7'd127);

    // quotient beyond 32 bits, 14-bit banks
    set_config(16'd1, 16'hFFFF, '0, 8'd255, 1'b1);
    send_event('1, 4'd4, KindOther, '0);
    send_event(32'd3, 4'd4, KindCoarse, 7'd127);
    send_event(32'd4, 4'd5, KindFine, '0);
    send_end();

    // injected pair itself out of range
    set_config('0, 16'hFFFF, 32'h1234_5678, 8'd128, 1'b0);
    send_event(32'd9, 4'd6, KindCoarse, '0);
    send_end();

    // mode switch in the middle of a track keeps the 14-bit bank
    set_config(16'hFFFF, '0, 32'd10, '0, 1'b1);
    send_event(32'd11, 4'd7, KindCoarse, 7'd127);
    drain();
    write_cfg(CfgMmaMode, '0);
    send_event(32'd12, 4'd7, KindFine, 7'd3);
    send_end();

    for (p = 0; p < 7; p++) begin
      set_config(pick_res(), pick_res(), ($urandom_range(0, 3) == 0) ? '1 : $urandom(),
                 pick_shift(), 1'($urandom_range(0, 1)));
      in_steady  = (p == 1 || p == 5);
      out_steady = (p == 3 || p == 5);
      if (p == 2) hold_req = 1'b1;
      if (p == 4) begin
        // every channel in use: longest run of injected pairs
        for (c = 0; c < CHANNELS_DEF; c++) begin
          send_event(rand_tick(), c[CH_W-1:0], kind_e'(2'($urandom_range(1, 3))), rand_dv());
        end
        send_end();
      end
      for (n = 0; n < 14; n++) begin
        if ($urandom_range(0, 11) == 0) send_end();
        else send_event(rand_tick(), 4'($urandom_range(0, 15)), rand_kind(), rand_dv());
      end
      if ($urandom_range(0, 1) == 1) send_end();
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("midi_event_retime_bank_remap_top test passed");
    end else begin
      $display("midi_event_retime_bank_remap_top test failed");
    end
    $finish;
  end

endmodule
